### design/rsas_pkg.sv
// ----------------------------------------------------------------------------
// Rotated sorted array search package
// Sizes, command codes and the queue entry type shared by the search core.
// ----------------------------------------------------------------------------
`default_nettype none

package rsas_pkg;

   localparam int DEPTH       = 64;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int COUNT_W     = $clog2(DEPTH + 1);
   localparam int VALUE_W     = 32;
   localparam int POS_W       = 6;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   typedef struct packed {
      logic                      is_search;
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_out_type;

endpackage

`default_nettype wire

### design/rotated_sorted_array_search_core.sv
// ----------------------------------------------------------------------------
// Rotated sorted array search core
// Loads a rotated ascending array and binary-searches it for target values.
// ----------------------------------------------------------------------------
// A load is taken by the back end in its idle state; a search takes a setup
// step and then element compares until it finds the target or the range empties.
// The compare loop is bound by the registered read of the element memory.
// Each search result is registered before it leaves the core; the strobe lasts
// one cycle and the receiver cannot stall it.
// Synchronous reset empties the queue and starts a fresh array; memory is not cleared.
`default_nettype none

module rotated_sorted_array_search_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output      logic                               busy,
   input  wire logic                               req_op,
   input  wire logic signed [rsas_pkg::VALUE_W-1:0] req_item_value,
   input  wire logic                               req_last_element,
   output      logic                               rsp_valid,
   output      logic                               rsp_found,
   output      logic [rsas_pkg::POS_W-1:0]         rsp_position
);
   import rsas_pkg::*;

   queue_out_type head;
   logic          pop;

   rsas_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .req_op           (req_op),
      .req_item_value   (req_item_value),
      .req_last_element (req_last_element),
      .pop              (pop),
      .busy             (busy),
      .head             (head)
   );

   rsas_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_found    (rsp_found),
      .rsp_position (rsp_position)
   );

endmodule

`default_nettype wire

### design/rsas_front.sv
// ----------------------------------------------------------------------------
// Rotated sorted array search front end
// Accepts commands, decodes the operation and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rsas_front (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic                               req_op,
   input  wire logic signed [rsas_pkg::VALUE_W-1:0] req_item_value,
   input  wire logic                               req_last_element,
   input  wire logic                               pop,
   output      logic                               busy,
   output      rsas_pkg::queue_out_type            head
);
   import rsas_pkg::*;

   cmd_type             queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   fill_ff, fill_in;
   cmd_type             cmd;
   logic                accept;
   logic                take;

   always_comb begin
      cmd.value = req_item_value;
      cmd.last  = req_last_element;
      unique case (req_op)
         OP_LOAD:   cmd.is_search = 1'b0;
         OP_SEARCH: cmd.is_search = 1'b1;
         default:   cmd.is_search = 1'b0;
      endcase
   end

   assign busy   = (fill_ff == QCNT_W'(QUEUE_DEPTH));
   assign accept = start && !busy;
   assign take   = pop && (fill_ff != '0);

   assign head.valid = (fill_ff != '0);
   assign head.cmd   = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (accept) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (accept && !take) begin
         fill_in = fill_ff + 1'b1;
      end else if (take && !accept) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

`default_nettype wire

### design/rsas_back.sv
// ----------------------------------------------------------------------------
// Rotated sorted array search back end
// Stores loaded elements, tracks the rotation point and runs the binary search.
// ----------------------------------------------------------------------------
`default_nettype none

module rsas_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire rsas_pkg::queue_out_type        head,
   output      logic                           pop,
   output      logic                           rsp_valid,
   output      logic                           rsp_found,
   output      logic [rsas_pkg::POS_W-1:0]     rsp_position
);
   import rsas_pkg::*;

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_SEARCH = 1'b1;

   logic signed [VALUE_W-1:0] mem [DEPTH];

   logic                      state_ff, state_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [COUNT_W-1:0]        rot_ff, rot_in;
   logic                      load_done_ff, load_done_in;
   logic signed [VALUE_W-1:0] first_ff, first_in;
   logic signed [VALUE_W-1:0] prev_ff, prev_in;
   logic signed [VALUE_W-1:0] target_ff, target_in;
   logic signed [VALUE_W-1:0] rd_data_ff;
   logic [COUNT_W-1:0]        lo_ff, lo_in;
   logic [COUNT_W-1:0]        hi_ff, hi_in;
   logic [ADDR_W-1:0]         mid_ff, mid_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]          rsp_position_ff, rsp_position_in;

   logic signed [VALUE_W-1:0] cmd_value;
   logic [COUNT_W-1:0]        cnt_eff, rot_eff, pivot;
   logic [COUNT_W-1:0]        setup_lo, setup_hi, step_lo, step_hi;
   logic [COUNT_W-1:0]        lo_c, hi_c, mid_c;
   logic                      go;
   logic [ADDR_W-1:0]         rd_addr;
   logic                      wr_en;
   logic [ADDR_W-1:0]         wr_addr;
   logic [ADDR_W+POS_W-1:0]   pos_ext;

   assign cmd_value = head.cmd.value;
   assign pop       = (state_ff == ST_IDLE) && head.valid;

   assign cnt_eff = load_done_ff ? '0 : count_ff;
   assign rot_eff = load_done_ff ? '0 : rot_ff;
   assign pivot   = (rot_ff == '0) ? count_ff : rot_ff;

   always_comb begin
      if (count_ff == '0) begin
         setup_lo = '0;
         setup_hi = '0;
      end else if (cmd_value >= first_ff) begin
         setup_lo = '0;
         setup_hi = pivot;
      end else begin
         setup_lo = pivot;
         setup_hi = count_ff;
      end
      if (target_ff < rd_data_ff) begin
         step_lo = lo_ff;
         step_hi = COUNT_W'(mid_ff);
      end else begin
         step_lo = COUNT_W'(mid_ff) + 1'b1;
         step_hi = hi_ff;
      end
      lo_c  = (state_ff == ST_IDLE) ? setup_lo : step_lo;
      hi_c  = (state_ff == ST_IDLE) ? setup_hi : step_hi;
      mid_c = lo_c + ((hi_c - lo_c) >> 1);
      go    = (lo_c < hi_c);
   end

   assign rd_addr = mid_c[ADDR_W-1:0];
   assign wr_addr = cnt_eff[ADDR_W-1:0];
   assign pos_ext = (ADDR_W + POS_W)'(mid_ff);

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      rot_in          = rot_ff;
      load_done_in    = load_done_ff;
      first_in        = first_ff;
      prev_in         = prev_ff;
      target_in       = target_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      mid_in          = mid_ff;
      wr_en           = 1'b0;
      rsp_valid_in    = 1'b0;
      rsp_found_in    = 1'b0;
      rsp_position_in = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid && !head.cmd.is_search) begin
               count_in     = cnt_eff;
               rot_in       = rot_eff;
               load_done_in = head.cmd.last;
               if (cnt_eff < COUNT_W'(DEPTH)) begin
                  if ((cnt_eff != '0) && (rot_eff == '0) && (prev_ff > cmd_value)) begin
                     rot_in = cnt_eff;
                  end
                  if (cnt_eff == '0) begin
                     first_in = cmd_value;
                  end
                  prev_in  = cmd_value;
                  wr_en    = 1'b1;
                  count_in = cnt_eff + 1'b1;
               end
            end else if (head.valid) begin
               target_in = cmd_value;
               if (go) begin
                  lo_in    = lo_c;
                  hi_in    = hi_c;
                  mid_in   = rd_addr;
                  state_in = ST_SEARCH;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_SEARCH: begin
            if (rd_data_ff == target_ff) begin
               rsp_valid_in    = 1'b1;
               rsp_found_in    = 1'b1;
               rsp_position_in = pos_ext[POS_W-1:0];
               state_in        = ST_IDLE;
            end else if (go) begin
               lo_in  = lo_c;
               hi_in  = hi_c;
               mid_in = rd_addr;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rot_ff       <= '0;
         load_done_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rot_ff       <= rot_in;
         load_done_ff <= load_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff        <= first_in;
      prev_ff         <= prev_in;
      target_ff       <= target_in;
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      mid_ff          <= mid_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= cmd_value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

endmodule

`default_nettype wire

### design/rsas_checker.sv
// ----------------------------------------------------------------------------
// Rotated sorted array search checker
// Port-level properties of the search core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rsas_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               start,
   input wire logic                               busy,
   input wire logic                               req_op,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_found,
   input wire logic [rsas_pkg::POS_W-1:0]         rsp_position
);
   import rsas_pkg::*;

   logic [2:0] pending_ff, pending_in;
   logic       search_xfer;

   assign search_xfer = start && !busy && (req_op == OP_SEARCH);

   always_comb begin
      pending_in = pending_ff;
      if (search_xfer && !rsp_valid) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_valid && !search_xfer && (pending_ff != '0)) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_miss_position_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_position == '0)
      else $error("miss result carries a nonzero position");

   a_result_has_search: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("result without an outstanding search");

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd4)
      else $error("more searches outstanding than the core can hold");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !busy)
      else $error("core not quiet after reset");

endmodule

bind rotated_sorted_array_search_core rsas_checker u_rsas_checker (.*);

`default_nettype wire
